[hw/rtl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kuz_pkg.sv]
package kuz_pkg;

    localparam int BLOCK_W = 128;
    localparam int NUM_RK  = 10;
    localparam int RK_AW   = 4;

    typedef logic [127:0] blk_t;

    localparam logic [7:0] LIN_COEF [16] = '{
        8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
        8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1};

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
        8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,
        8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,
        8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
        8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,
        8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,
        8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
        8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,
        8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,
        8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
        8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,
        8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,
        8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
        8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,
        8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,
        8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
        8'd57,8'd75,8'd99,8'd182};

    localparam logic [7:0] SBOX_INV [256] = '{
        8'd165,8'd45,8'd50,8'd143,8'd14,8'd48,8'd56,8'd192,8'd84,8'd230,8'd158,8'd57,
        8'd85,8'd126,8'd82,8'd145,
        8'd100,8'd3,8'd87,8'd90,8'd28,8'd96,8'd7,8'd24,8'd33,8'd114,8'd168,8'd209,
        8'd41,8'd198,8'd164,8'd63,
        8'd224,8'd39,8'd141,8'd12,8'd130,8'd234,8'd174,8'd180,8'd154,8'd99,8'd73,8'd229,
        8'd66,8'd228,8'd21,8'd183,
        8'd200,8'd6,8'd112,8'd157,8'd65,8'd117,8'd25,8'd201,8'd170,8'd252,8'd77,8'd191,
        8'd42,8'd115,8'd132,8'd213,
        8'd195,8'd175,8'd43,8'd134,8'd167,8'd177,8'd178,8'd91,8'd70,8'd211,8'd159,8'd253,
        8'd212,8'd15,8'd156,8'd47,
        8'd155,8'd67,8'd239,8'd217,8'd121,8'd182,8'd83,8'd127,8'd193,8'd240,8'd35,8'd231,
        8'd37,8'd94,8'd181,8'd30,
        8'd162,8'd223,8'd166,8'd254,8'd172,8'd34,8'd249,8'd226,8'd74,8'd188,8'd53,8'd202,
        8'd238,8'd120,8'd5,8'd107,
        8'd81,8'd225,8'd89,8'd163,8'd242,8'd113,8'd86,8'd17,8'd106,8'd137,8'd148,8'd101,
        8'd140,8'd187,8'd119,8'd60,
        8'd123,8'd40,8'd171,8'd210,8'd49,8'd222,8'd196,8'd95,8'd204,8'd207,8'd118,8'd44,
        8'd184,8'd216,8'd46,8'd54,
        8'd219,8'd105,8'd179,8'd20,8'd149,8'd190,8'd98,8'd161,8'd59,8'd22,8'd102,8'd233,
        8'd92,8'd108,8'd109,8'd173,
        8'd55,8'd97,8'd75,8'd185,8'd227,8'd186,8'd241,8'd160,8'd133,8'd131,8'd218,8'd71,
        8'd197,8'd176,8'd51,8'd250,
        8'd150,8'd111,8'd110,8'd194,8'd246,8'd80,8'd255,8'd93,8'd169,8'd142,8'd23,8'd27,
        8'd151,8'd125,8'd236,8'd88,
        8'd247,8'd31,8'd251,8'd124,8'd9,8'd13,8'd122,8'd103,8'd69,8'd135,8'd220,8'd232,
        8'd79,8'd29,8'd78,8'd4,
        8'd235,8'd248,8'd243,8'd62,8'd61,8'd189,8'd138,8'd136,8'd221,8'd205,8'd11,8'd19,
        8'd152,8'd2,8'd147,8'd128,
        8'd144,8'd208,8'd36,8'd52,8'd203,8'd237,8'd244,8'd206,8'd153,8'd16,8'd68,8'd64,
        8'd146,8'd58,8'd1,8'd38,
        8'd18,8'd26,8'd72,8'd104,8'd245,8'd129,8'd139,8'd199,8'd214,8'd32,8'd10,8'd8,
        8'd0,8'd76,8'd215,8'd116};

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] p;
        logic [7:0] a;
        p = '0;
        a = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) p = p ^ a;
            a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
        end
        return p;
    endfunction

    // byte 0 is bits 127:120
    function automatic logic [7:0] byte_at(input blk_t b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // one R step; the full L is a constant GF(2) matrix after synthesis
    function automatic blk_t r_fwd(input blk_t b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(LIN_COEF[i], byte_at(b, i));
        return {acc, b[127:8]};
    endfunction

    function automatic blk_t r_inv(input blk_t b);
        logic [7:0] acc;
        acc = gf_mul(LIN_COEF[15], byte_at(b, 0));
        for (int i = 0; i < 15; i++) acc = acc ^ gf_mul(LIN_COEF[i], byte_at(b, i + 1));
        return {b[119:0], acc};
    endfunction

    function automatic blk_t lin_fwd(input blk_t b);
        blk_t t;
        t = b;
        for (int r = 0; r < 16; r++) t = r_fwd(t);
        return t;
    endfunction

    function automatic blk_t lin_inv(input blk_t b);
        blk_t t;
        t = b;
        for (int r = 0; r < 16; r++) t = r_inv(t);
        return t;
    endfunction

    function automatic blk_t sub_fwd(input blk_t b);
        blk_t t;
        for (int i = 0; i < 16; i++) t[127 - 8*i -: 8] = SBOX[b[127 - 8*i -: 8]];
        return t;
    endfunction

    function automatic blk_t sub_inv(input blk_t b);
        blk_t t;
        for (int i = 0; i < 16; i++) t[127 - 8*i -: 8] = SBOX_INV[b[127 - 8*i -: 8]];
        return t;
    endfunction

endpackage

[hw/rtl/kuz_rk_mem.sv]
module kuz_rk_mem
    import kuz_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [RK_AW-1:0]  waddr,
    input  blk_t              wdata,
    input  logic [RK_AW-1:0]  raddr,
    output blk_t              rdata
);

    blk_t mem [NUM_RK];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/kuz_core.sv]
module kuz_core
    import kuz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        op,
    input  logic        expand,
    input  logic        take,
    input  blk_t        key_a,
    input  blk_t        key_c,
    input  blk_t        blk_in,
    output logic        busy,
    output logic        done,
    output blk_t        blk_out
);

    typedef enum logic [1:0] {S_IDLE, S_EXP, S_RUN, S_DONE} state_t;

    state_t             state_reg;
    logic               op_reg;
    logic [5:0]         j_reg;
    logic [RK_AW-1:0]   cnt_reg;
    blk_t               a_reg, c_reg, b_reg;

    logic               we;
    logic [RK_AW-1:0]   waddr, raddr, cnt_step;
    blk_t               wdata, rk;
    logic               last_round;

    blk_t               feistel;
    blk_t               enc_next, dec_next;

    kuz_rk_mem u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rk)
    );

    always_comb
    begin
        feistel    = lin_fwd(sub_fwd(lin_fwd({{(BLOCK_W - 6){1'b0}}, j_reg}) ^ a_reg)) ^ c_reg;
        enc_next   = lin_fwd(sub_fwd(b_reg ^ rk));
        dec_next   = sub_inv(lin_inv(b_reg ^ rk));
        last_round = op_reg ? (cnt_reg == '0) : (cnt_reg == RK_AW'(NUM_RK - 1));
        cnt_step   = op_reg ? cnt_reg - 1'b1 : cnt_reg + 1'b1;
        // j = 0 mod 8: c of the pair (equals a before the step); j = 1 mod 8: its a
        we         = (state_reg == S_EXP) && (j_reg[2:1] == 2'b00);
        waddr      = {j_reg[5:3], ~j_reg[0]};
        wdata      = (j_reg == 6'd0) ? c_reg : a_reg;
        unique case (state_reg)
            S_IDLE: raddr = op ? RK_AW'(NUM_RK - 1) : '0;
            S_EXP:  raddr = op_reg ? RK_AW'(NUM_RK - 1) : '0;
            S_RUN:  raddr = last_round ? cnt_reg : cnt_step;
            S_DONE: raddr = cnt_reg;
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = (state_reg == S_DONE);
    assign blk_out = b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= 1'b0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            a_reg     <= '0;
            c_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op;
                        b_reg     <= blk_in;
                        a_reg     <= key_a;
                        c_reg     <= key_c;
                        j_reg     <= '0;
                        cnt_reg   <= op ? RK_AW'(NUM_RK - 1) : '0;
                        state_reg <= expand ? S_EXP : S_RUN;
                    end
                end
                S_EXP:
                begin
                    // j = 1..32 are Feistel steps; j = 0 and 33 only write
                    if (j_reg != 6'd0 && j_reg != 6'd33)
                    begin
                        a_reg <= feistel;
                        c_reg <= a_reg;
                    end
                    j_reg <= j_reg + 6'd1;
                    if (j_reg == 6'd33)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last_round)
                    begin
                        b_reg     <= b_reg ^ rk;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        b_reg   <= op_reg ? dec_next : enc_next;
                        cnt_reg <= cnt_step;
                    end
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[hw/rtl/kuznyechik_block_cipher_unit.sv]
// channel  | dir | tdata                                | tuser
// s_axis   | in  | [63:0] block_hi, [127:64] block_lo   | op
// m_axis   | out | [63:0] result_hi, [127:64] result_lo | -
// cfg      | in  | cfg_index 0..3 selects key word 0..3 | -
// A block takes one round key per step, each read from the round-key memory, then passes into
// the output register; no new beat is taken before the previous block has left the core.
// The first block after reset or a key write is preceded by key expansion.
// Reset clears control and keys; round keys are rebuilt before the first block.
// Input stalls while a block is in the core; the core holds a finished block
// while the output register is full and not being read.
module kuznyechik_block_cipher_unit
    import kuz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_hi, block_lo
    input  logic         s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // result_hi, result_lo
);

`include "assert_macros.svh"

    logic [63:0] key_reg [4];
    logic        pend_reg;
    logic        busy, done, start, take;
    blk_t        blk_out;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;
    assign take  = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0; key_reg[1] <= '0; key_reg[2] <= '0; key_reg[3] <= '0;
            pend_reg   <= 1'b1;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg[cfg_index] <= cfg_data;
                pend_reg <= 1'b1;
            end
            else if (start)
            begin
                pend_reg <= 1'b0;
            end
            if (done && take)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && take)
        begin
            m_axis_tdata <= {blk_out[63:0], blk_out[127:64]};
        end
    end

    kuz_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (s_axis_tuser),
        .expand  (pend_reg),
        .take    (take),
        .key_a   ({key_reg[0], key_reg[1]}),
        .key_c   ({key_reg[2], key_reg[3]}),
        .blk_in  ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .busy    (busy),
        .done    (done),
        .blk_out (blk_out)
    );

    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, busy, !s_axis_tready, "ready while busy")
    `ASSERT_NEXT(a_done_valid, clk, rst_n, done && take, m_axis_tvalid, "done lost")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped")

endmodule
